/* sv/mbh_pkg.sv */
// Shared types, constants and microcode program for the murmur3 bucket hash.
package mbh_pkg;

  localparam logic [31:0] C1       = 32'hcc9e2d51;
  localparam logic [31:0] C2       = 32'h1b873593;
  localparam logic [31:0] BODY_ADD = 32'he6546b64;
  localparam logic [31:0] FMIX1    = 32'h85ebca6b;
  localparam logic [31:0] FMIX2    = 32'hc2b2ae35;
  localparam logic [31:0] BODY_MUL = 32'd5;

  localparam logic [31:0] CAP_RESET = 32'd1024;
  localparam logic [31:0] SEED_RESET = 32'd0;

  localparam logic [0:0] REG_SEED = 1'd0;
  localparam logic [0:0] REG_CAP  = 1'd1;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_KC1,    // k = rotl(k * C1, 15)
    OP_KC2,    // h ^= k * C2
    OP_BODY,   // h = rotl(h, 13) * 5 + BODY_ADD
    OP_FX0,    // h ^= len, then h ^= h >> 16
    OP_FM1,    // h = h * FMIX1, then ^= >> 13
    OP_FM2,    // h = h * FMIX2, then ^= >> 16
    OP_DIV,    // launch bucket modulo
    OP_OUT     // hand result to output register
  } op_t;

  typedef enum logic [2:0] {
    CN_NEXT,      // advance
    CN_ZERO,      // jump when no byte in word
    CN_PART,      // jump when word is not full
    CN_BODY_END,  // stop unless last word
    CN_WAIT_DIV,  // hold while modulo runs
    CN_END        // stop once output slot is free
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic out_fire;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic last;
  } dp_stat_t;

  localparam pc_t PC_FIN = 4'd3;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_KC1,  cond: CN_ZERO,     target: PC_FIN};
      4'd1:    w = '{op: OP_KC2,  cond: CN_PART,     target: PC_FIN};
      4'd2:    w = '{op: OP_BODY, cond: CN_BODY_END, target: PC_FIN};
      4'd3:    w = '{op: OP_FX0,  cond: CN_NEXT,     target: PC_FIN};
      4'd4:    w = '{op: OP_FM1,  cond: CN_NEXT,     target: PC_FIN};
      4'd5:    w = '{op: OP_FM2,  cond: CN_NEXT,     target: PC_FIN};
      4'd6:    w = '{op: OP_DIV,  cond: CN_NEXT,     target: PC_FIN};
      4'd7:    w = '{op: OP_NOP,  cond: CN_WAIT_DIV, target: PC_FIN};
      4'd8:    w = '{op: OP_OUT,  cond: CN_END,      target: PC_FIN};
      default: w = '{op: OP_NOP,  cond: CN_END,      target: PC_FIN};
    endcase
    return w;
  endfunction

endpackage

/* sv/mbh_seq.sv */
// Microcode sequencer: step counter, control ROM and branch logic.
module mbh_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mbh_pkg::dp_stat_t   dp_stat,
  input  logic                div_busy,
  input  logic                out_free,
  output mbh_pkg::ctrl_t      ctrl,
  output logic                busy
);

  mbh_pkg::pc_t    pc;
  mbh_pkg::pc_t    pc_next;
  logic            running;
  logic            running_next;
  mbh_pkg::uword_t word;
  mbh_pkg::pc_t    pc_inc;

  assign word   = mbh_pkg::ucode(pc);
  assign pc_inc = pc + mbh_pkg::pc_t'(1);
  assign busy   = running;

  assign ctrl.op       = running ? word.op : mbh_pkg::OP_NOP;
  assign ctrl.out_fire = running && (word.op == mbh_pkg::OP_OUT) && out_free;

  always_comb begin
    pc_next      = pc;
    running_next = running;
    if (start) begin
      pc_next      = '0;
      running_next = 1'b1;
    end else if (running) begin
      unique case (word.cond)
        mbh_pkg::CN_NEXT:     pc_next = pc_inc;
        mbh_pkg::CN_ZERO:     pc_next = dp_stat.cnt_zero ? word.target : pc_inc;
        mbh_pkg::CN_PART:     pc_next = dp_stat.cnt_full ? pc_inc : word.target;
        mbh_pkg::CN_BODY_END: begin
          if (dp_stat.last) pc_next = pc_inc;
          else running_next = 1'b0;
        end
        mbh_pkg::CN_WAIT_DIV: pc_next = div_busy ? pc : pc_inc;
        mbh_pkg::CN_END:      running_next = !out_free;
        default:              running_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      running <= 1'b0;
    end else begin
      pc      <= pc_next;
      running <= running_next;
    end
  end

endmodule

/* sv/mbh_dp.sv */
// Hash datapath: running hash, scratch word, byte length and shared multiplier.
module mbh_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [31:0]         key_word,
  input  logic [2:0]          byte_count,
  input  logic                last_word,
  input  logic [31:0]         hash_seed,
  input  mbh_pkg::ctrl_t      ctrl,
  output mbh_pkg::dp_stat_t   dp_stat,
  output logic [31:0]         hash
);

  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] len;
  logic [2:0]  cnt;
  logic        last;
  logic        active;

  logic [2:0]  cnt_eff;
  logic [31:0] mask;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] hx;

  // Non-last words always count as full; oversized counts clamp to four.
  assign cnt_eff = (!last_word || byte_count > 3'd4) ? 3'd4 : byte_count;

  always_comb begin
    case (cnt_eff)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    mul_a = k;
    mul_b = mbh_pkg::C1;
    unique case (ctrl.op)
      mbh_pkg::OP_KC1:  begin mul_a = k; mul_b = mbh_pkg::C1; end
      mbh_pkg::OP_KC2:  begin mul_a = k; mul_b = mbh_pkg::C2; end
      mbh_pkg::OP_BODY: begin mul_a = {h[18:0], h[31:19]}; mul_b = mbh_pkg::BODY_MUL; end
      mbh_pkg::OP_FM1:  begin mul_a = h; mul_b = mbh_pkg::FMIX1; end
      mbh_pkg::OP_FM2:  begin mul_a = h; mul_b = mbh_pkg::FMIX2; end
      default:          begin mul_a = k; mul_b = mbh_pkg::C1; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign hx   = h ^ len;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      len    <= '0;
    end else if (load) begin
      k      <= key_word & mask;
      cnt    <= cnt_eff;
      last   <= last_word;
      h      <= active ? h : hash_seed;
      len    <= (active ? len : 32'd0) + {29'd0, cnt_eff};
      active <= 1'b1;
    end else begin
      unique case (ctrl.op)
        mbh_pkg::OP_KC1:  k <= {prod[16:0], prod[31:17]};
        mbh_pkg::OP_KC2:  h <= h ^ prod;
        mbh_pkg::OP_BODY: h <= prod + mbh_pkg::BODY_ADD;
        mbh_pkg::OP_FX0:  h <= hx ^ (hx >> 16);
        mbh_pkg::OP_FM1:  h <= prod ^ (prod >> 13);
        mbh_pkg::OP_FM2:  h <= prod ^ (prod >> 16);
        default:          ;
      endcase
      // Close the key once its result leaves; next word reloads the seed.
      if (ctrl.out_fire) active <= 1'b0;
    end
  end

  assign dp_stat.cnt_zero = (cnt == 3'd0);
  assign dp_stat.cnt_full = (cnt == 3'd4);
  assign dp_stat.last     = last;
  assign hash             = h;

endmodule

/* sv/mbh_div.sv */
// Radix-2 restoring modulo unit, one quotient bit per cycle.
module mbh_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] rem
);

  logic [31:0] r;
  logic [31:0] q;
  logic [31:0] d;
  logic [4:0]  step;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {r, q[31]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 5'd31;
      r    <= '0;
      q    <= dividend;
      d    <= divisor;
    end else if (busy) begin
      // Remainder stays below the divisor, so 32 bits hold it.
      r    <= diff[32] ? trial[31:0] : diff[31:0];
      q    <= {q[30:0], 1'b0};
      step <= step - 5'd1;
      if (step == 5'd0) busy <= 1'b0;
    end
  end

  // A zero divisor yields bucket zero.
  assign rem = (d == 32'd0) ? 32'd0 : r;

endmodule

/* sv/murmur3_bucket_hash_top.sv */
// MurmurHash3 x86_32 over streamed key words, with bucket modulo; top level.
// A word that does not end a key runs KC1, KC2 and BODY in turn on the shared 32x32
// multiplier; a last word also holds the input through finalize, modulo and output stalls.
// s_tready stays low while a word is in process, so a new word is taken only once the last
// is done; the bucket index comes from the bit-serial modulo unit.
// Reset (rst, synchronous): seed 0, capacity 1024, no key open, no output.
module murmur3_bucket_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // key_word[31:0], byte_count[34:32], zero pad
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // raw_hash[31:0], bucket_index[63:32]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]       hash_seed;
  logic [31:0]       table_capacity;
  logic              accept;
  logic              busy;
  logic              out_free;
  logic              div_start;
  logic              div_busy;
  logic [31:0]       div_rem;
  logic [31:0]       hash;
  mbh_pkg::ctrl_t    ctrl;
  mbh_pkg::dp_stat_t dp_stat;

  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = (ctrl.op == mbh_pkg::OP_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed      <= mbh_pkg::SEED_RESET;
      table_capacity <= mbh_pkg::CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbh_pkg::REG_SEED: hash_seed      <= cfg_data;
        mbh_pkg::REG_CAP:  table_capacity <= cfg_data;
        default:           ;
      endcase
    end
  end

  mbh_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dp_stat  (dp_stat),
    .div_busy (div_busy),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  mbh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .key_word   (s_tdata[31:0]),
    .byte_count (s_tdata[34:32]),
    .last_word  (s_tlast),
    .hash_seed  (hash_seed),
    .ctrl       (ctrl),
    .dp_stat    (dp_stat),
    .hash       (hash)
  );

  mbh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hash),
    .divisor  (table_capacity - 32'd1),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_fire) m_tdata <= {div_rem, hash};
  end

endmodule
